// ----- hw/rtl/frs_pkg.sv -----
// Package: shared types and constants of the frame rate statistics block.
`timescale 1ns / 1ps

package frs_pkg;

  // Field widths
  localparam int unsigned TimeW  = 48;
  localparam int unsigned RateW  = 18;
  localparam int unsigned FrameW = 32;

  // Rate for a zero delta, and the dividend of the rate division
  localparam logic [RateW-1:0] RateFull = 18'd256000;
  // Minimum tracker value when no frame has been seen
  localparam logic [RateW-1:0] RateNone = '1;

  // Command codes
  localparam logic CmdFrame = 1'b0;
  localparam logic CmdClear = 1'b1;

  // Input item
  typedef struct packed {
    logic             cmd;
    logic [TimeW-1:0] timestamp_ms;
  } frs_in_t;

  // Result item
  typedef struct packed {
    logic [TimeW-1:0]  delta_ms;
    logic [RateW-1:0]  frame_rate;
    logic [RateW-1:0]  rate_average;
    logic [RateW-1:0]  rate_maximum;
    logic [RateW-1:0]  rate_minimum;
    logic [FrameW-1:0] frames_seen;
  } frs_out_t;

endpackage

// ----- hw/rtl/frs_divider.sv -----
// Restoring serial divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module frs_divider #(
  parameter int unsigned DividendW = 23,
  parameter int unsigned DivisorW  = 18
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 done_o,
  output logic [DividendW-1:0] quotient_o
);

  localparam int unsigned StepW = $clog2(DividendW + 1);

  logic                 busy_q;
  logic                 done_q;
  logic [StepW-1:0]     step_q;
  logic [DivisorW:0]    rem_q;
  logic [DividendW-1:0] quo_q;
  logic [DivisorW-1:0]  divisor_q;

  logic [DivisorW:0]    rem_sh;
  logic [DivisorW+1:0]  diff;
  logic                 take;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh = {rem_q[DivisorW-1:0], quo_q[DividendW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, divisor_q};
    take   = ~diff[DivisorW+1];
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == StepW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(DividendW);
      end else if (busy_q) begin
        step_q <= step_q - StepW'(1);
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath; the quotient bits replace the dividend bits as they shift out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= '0;
      quo_q     <= dividend_i;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= take ? diff[DivisorW:0] : rem_sh;
      quo_q <= {quo_q[DividendW-2:0], take};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- hw/rtl/frame_rate_statistics_core.sv -----
// Top level: frame rate meter with a rate ring, running extremes and averages.
//
//  channel | signals                          | direction | item
//  --------+----------------------------------+-----------+---------------------
//  in      | in_valid_i, in_ready_o, in_data_i | to core  | frame tick or clear
//  out     | out_valid_o, out_ready_i, out_data_o | from core | statistics result
//
// A frame item passes from acceptance through a serial rate division, one ring
// write, a walk over the filled ring entries and a serial mean division, and
// only then can the next item be accepted. The rate division is skipped when
// the delta is zero or at least 2^18.
// A clear item goes straight to the result stage.
// Reset clears all statistics; the ring memory is not cleared, only written
// entries are read. A held result in the output register does not stop the next
// item from being accepted.
`timescale 1ns / 1ps

module frame_rate_statistics_core
  import frs_pkg::*;
#(
  parameter int unsigned WINDOW = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  frs_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output frs_out_t out_data_o
);

  localparam int unsigned CntW = $clog2(WINDOW + 1);
  localparam int unsigned IdxW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SumW = RateW + CntW;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StDivR  = 6'b000010,
    StWrite = 6'b000100,
    StSum   = 6'b001000,
    StDivA  = 6'b010000,
    StDone  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Statistics state
  logic [TimeW-1:0]  prev_time_q;
  logic [IdxW-1:0]   wr_pos_q;
  logic [CntW-1:0]   filled_q;
  logic [RateW-1:0]  high_q;
  logic [RateW-1:0]  low_q;
  logic [FrameW-1:0] frames_q;

  // Per-item working registers
  logic [TimeW-1:0]  delta_q;
  logic [RateW-1:0]  rate_q;
  logic [RateW-1:0]  avg_q;
  logic [SumW-1:0]   sum_q;
  logic [CntW-1:0]   rd_cnt_q;
  logic              rd_vld_q;

  // Output register
  logic              out_valid_q;
  frs_out_t          out_q;

  // Ring memory
  logic [RateW-1:0]  ring_mem [WINDOW];
  logic [RateW-1:0]  ring_rd_q;
  logic              ring_we;
  logic              ring_re;

  // Divider
  logic              div_start;
  logic [SumW-1:0]   div_dividend;
  logic [RateW-1:0]  div_divisor;
  logic              div_done;
  logic [SumW-1:0]   div_quo;

  logic              in_acc;
  logic [TimeW-1:0]  delta_d;
  logic              delta_zero;
  logic              delta_big;
  logic              sum_last;
  logic              out_free;

  assign in_acc     = in_valid_i && in_ready_o;
  assign delta_d    = in_data_i.timestamp_ms - prev_time_q;
  assign delta_zero = (delta_d == '0);
  assign delta_big  = |delta_d[TimeW-1:RateW];
  assign sum_last   = (rd_cnt_q == filled_q) && !rd_vld_q;
  assign out_free   = !out_valid_q || out_ready_i;

  assign ring_we = (state_q == StWrite);
  assign ring_re = (state_q == StSum) && (rd_cnt_q < filled_q);

  // Divider operands: rate division at acceptance, mean division after the walk
  always_comb begin
    if (state_q == StIdle) begin
      div_start    = in_acc && (in_data_i.cmd == CmdFrame) && !delta_zero && !delta_big;
      div_dividend = {{(SumW-RateW){1'b0}}, RateFull};
      div_divisor  = delta_d[RateW-1:0];
    end else begin
      div_start    = (state_q == StSum) && sum_last;
      div_dividend = sum_q;
      div_divisor  = {{(RateW-CntW){1'b0}}, filled_q};
    end
  end

  frs_divider #(
    .DividendW(SumW),
    .DivisorW (RateW)
  ) u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (in_data_i.cmd == CmdClear) begin
            state_d = StDone;
          end else if (div_start) begin
            state_d = StDivR;
          end else begin
            state_d = StWrite;
          end
        end
      end
      StDivR: begin
        if (div_done) begin
          state_d = StWrite;
        end
      end
      StWrite: state_d = StSum;
      StSum: begin
        if (sum_last) begin
          state_d = StDivA;
        end
      end
      StDivA: begin
        if (div_done) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control and statistics registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      prev_time_q <= '0;
      wr_pos_q    <= '0;
      filled_q    <= '0;
      high_q      <= '0;
      low_q       <= RateNone;
      frames_q    <= '0;
      rd_cnt_q    <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= ring_re;

      // Item acceptance: clear or frame bookkeeping
      if (in_acc) begin
        if (in_data_i.cmd == CmdClear) begin
          prev_time_q <= '0;
          wr_pos_q    <= '0;
          filled_q    <= '0;
          high_q      <= '0;
          low_q       <= RateNone;
        end else begin
          prev_time_q <= in_data_i.timestamp_ms;
          frames_q    <= frames_q + FrameW'(1);
        end
      end

      // Ring write and extremes
      if (state_q == StWrite) begin
        wr_pos_q <= (wr_pos_q == IdxW'(WINDOW - 1)) ? '0 : wr_pos_q + IdxW'(1);
        if (filled_q != CntW'(WINDOW)) begin
          filled_q <= filled_q + CntW'(1);
        end
        if (rate_q > high_q) begin
          high_q <= rate_q;
        end
        if (rate_q < low_q) begin
          low_q <= rate_q;
        end
        rd_cnt_q <= '0;
      end else if (ring_re) begin
        rd_cnt_q <= rd_cnt_q + CntW'(1);
      end

      // Output register
      if ((state_q == StDone) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (in_data_i.cmd == CmdClear) begin
        delta_q <= '0;
        rate_q  <= '0;
        avg_q   <= '0;
      end else begin
        delta_q <= delta_d;
        if (delta_zero) begin
          rate_q <= RateFull;
        end else if (delta_big) begin
          rate_q <= '0;
        end
      end
    end
    if ((state_q == StDivR) && div_done) begin
      rate_q <= div_quo[RateW-1:0];
    end
    if (state_q == StWrite) begin
      sum_q <= '0;
    end else if (rd_vld_q) begin
      sum_q <= sum_q + {{(SumW-RateW){1'b0}}, ring_rd_q};
    end
    if ((state_q == StDivA) && div_done) begin
      avg_q <= div_quo[RateW-1:0];
    end
    if ((state_q == StDone) && out_free) begin
      out_q.delta_ms     <= delta_q;
      out_q.frame_rate   <= rate_q;
      out_q.rate_average <= avg_q;
      out_q.rate_maximum <= high_q;
      out_q.rate_minimum <= low_q;
      out_q.frames_seen  <= frames_q;
    end
  end

  // Rate ring: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[wr_pos_q] <= rate_q;
    end
    if (ring_re) begin
      ring_rd_q <= ring_mem[rd_cnt_q[IdxW-1:0]];
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
